// File: hw/rtl/mhpq_pkg.sv
// Shared types and codes for the min-heap priority queue.
// No dependencies; imported by every module of the block.
package mhpq_pkg;

	// One heap entry: key plus payload.
	typedef struct packed {
		logic signed [9:0] num;
		logic [7:0]        sym;
		logic [31:0]       freq;
	} entry_t;

	// Operation codes carried on the input tuser.
	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_BUILD   = 2'd1,
		OP_INSERT  = 2'd2,
		OP_EXTRACT = 2'd3
	} op_t;

	// Status codes reported with every result.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam logic signed [9:0] DUMMY_NUM = -10'sd1;

endpackage

// File: hw/rtl/mhpq_store.sv
// Heap entry memory: one write port and one read port with registered data.
// Depends on mhpq_pkg for the entry type.
module mhpq_store import mhpq_pkg::*; #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata_q
);

	entry_t mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

endmodule

// File: hw/rtl/min_heap_priority_queue.sv
// Binary min-heap priority queue with a sift sequencer over one read and one write port.
// Load writes the entry on acceptance; insert sifts the new entry up to its place; extract
// takes the root and sifts the last entry down from it; build sifts down every inner node,
// then strips zero-frequency roots and pads a lone entry with a dummy.
// One transaction is worked at a time; the memory read port sets the step rate.
// Reset (arst_n low) empties the heap; memory contents are not cleared.
module min_heap_priority_queue import mhpq_pkg::*; #(
	parameter int CAPACITY = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [31:0] in_frequency, [39:32] in_symbol, [49:40] in_node_number, [55:50] zero
	input  logic [55:0] s_tdata,
	// [1:0] operation
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [31:0] out_frequency, [39:32] out_symbol, [49:40] out_node_number,
	// [59:50] entry_count, [63:60] zero
	output logic [63:0] m_tdata,
	// [0] out_valid, [2:1] status
	output logic [2:0]  m_tuser
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = AW + 2;

	typedef enum logic [15:0] {
		S_IDLE = 16'h0001, S_SD_A = 16'h0002, S_SD_B = 16'h0004, S_SD_C = 16'h0008,
		S_SU_A = 16'h0010, S_SU_B = 16'h0020, S_EX_A = 16'h0040, S_EX_B = 16'h0080,
		S_POP  = 16'h0100, S_BH_A = 16'h0200, S_BH_B = 16'h0400, S_ZR_A = 16'h0800,
		S_ZR_B = 16'h1000, S_DM_A = 16'h2000, S_DM_B = 16'h4000, S_DONE = 16'h8000
	} state_t;

	typedef enum logic [1:0] {
		RET_DONE  = 2'd0,
		RET_BUILD = 2'd1,
		RET_ZERO  = 2'd2
	} ret_t;

	state_t        state_q;
	ret_t          ret_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] bi_q;
	entry_t        cur_q;
	entry_t        left_q;
	entry_t        res_q;
	logic          res_valid_q;
	status_t       status_q;

	logic          out_valid_q;
	entry_t        out_entry_q;
	status_t       out_status_q;
	logic [9:0]    out_count_q;
	logic          m_tvalid_q;

	logic          we;
	logic [AW-1:0] waddr;
	entry_t        wdata;
	logic [AW-1:0] raddr;
	entry_t        rdata;

	entry_t        in_entry;
	op_t           in_op;
	logic          full;
	logic          accept;
	logic [XW-1:0] lchild;
	logic [XW-1:0] rchild;
	logic [XW-1:0] count_x;
	logic          have_l;
	logic          have_r;
	logic          take_l;
	logic          take_r;
	entry_t        best_l;
	logic [AW-1:0] parent;
	logic [AW-1:0] last_addr;
	logic          up_swap;
	logic [CW+9:0] count_ext;

	mhpq_store #(.DEPTH(CAPACITY), .AW(AW)) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr   (raddr),
		.rdata_q (rdata)
	);

	// Input unpacking and handshake.
	assign in_entry.freq = s_tdata[31:0];
	assign in_entry.sym  = s_tdata[39:32];
	assign in_entry.num  = s_tdata[49:40];
	assign in_op         = op_t'(s_tuser);
	assign s_tready      = (state_q == S_IDLE);
	assign accept        = s_tvalid && s_tready;
	assign full          = (count_q == CW'(CAPACITY));

	// Index arithmetic for the tree walk.
	assign lchild    = {1'b0, idx_q, 1'b1};
	assign rchild    = lchild + XW'(1);
	assign count_x   = XW'(count_q);
	assign have_l    = lchild < count_x;
	assign have_r    = rchild < count_x;
	assign parent    = (idx_q - AW'(1)) >> 1;
	assign last_addr = AW'(count_q - CW'(1));

	// Child selection: strict less-than, left child wins ties.
	assign take_l  = have_l && (left_q.freq < cur_q.freq);
	assign best_l  = take_l ? left_q : cur_q;
	assign take_r  = have_r && (rdata.freq < best_l.freq);
	assign up_swap = cur_q.freq < rdata.freq;

	// Memory port control by state.
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = cur_q;
		raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && in_op == OP_LOAD && !full) begin
					we    = 1'b1;
					waddr = AW'(count_q);
					wdata = in_entry;
				end
			end
			S_SD_A: begin
				raddr = lchild[AW-1:0];
				we    = !have_l;
			end
			S_SD_B: raddr = rchild[AW-1:0];
			S_SD_C: begin
				we = 1'b1;
				if (take_r) begin
					wdata = rdata;
				end else if (take_l) begin
					wdata = left_q;
				end
			end
			S_SU_A: begin
				raddr = parent;
				we    = (idx_q == '0);
			end
			S_SU_B: begin
				we = 1'b1;
				if (up_swap) begin
					wdata = rdata;
				end
			end
			S_EX_A, S_ZR_A, S_DM_A: raddr = '0;
			S_EX_B, S_ZR_B: raddr = last_addr;
			S_BH_A: raddr = bi_q - AW'(1);
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= RET_DONE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
			status_q    <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_valid_q <= 1'b0;
						status_q    <= ST_OK;
						res_q       <= '0;
						case (in_op)
							OP_LOAD: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									count_q <= count_q + CW'(1);
								end
								state_q <= S_DONE;
							end
							OP_INSERT: begin
								if (full) begin
									status_q <= ST_FULL;
									state_q  <= S_DONE;
								end else begin
									cur_q   <= in_entry;
									idx_q   <= AW'(count_q);
									count_q <= count_q + CW'(1);
									state_q <= S_SU_A;
								end
							end
							OP_BUILD: begin
								bi_q    <= AW'(count_q >> 1);
								state_q <= S_BH_A;
							end
							default: begin
								if (count_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_EX_A;
								end
							end
						endcase
					end
				end
				// Sift-down: read left, read right, then compare and move.
				S_SD_A: begin
					if (have_l) begin
						state_q <= S_SD_B;
					end else begin
						case (ret_q)
							RET_BUILD: state_q <= S_BH_A;
							RET_ZERO:  state_q <= S_ZR_A;
							default:   state_q <= S_DONE;
						endcase
					end
				end
				S_SD_B: begin
					left_q  <= rdata;
					state_q <= S_SD_C;
				end
				S_SD_C: begin
					if (take_r) begin
						idx_q   <= rchild[AW-1:0];
						state_q <= S_SD_A;
					end else if (take_l) begin
						idx_q   <= lchild[AW-1:0];
						state_q <= S_SD_A;
					end else begin
						case (ret_q)
							RET_BUILD: state_q <= S_BH_A;
							RET_ZERO:  state_q <= S_ZR_A;
							default:   state_q <= S_DONE;
						endcase
					end
				end
				// Sift-up: read parent, then compare and move.
				S_SU_A: state_q <= (idx_q == '0) ? S_DONE : S_SU_B;
				S_SU_B: begin
					if (up_swap) begin
						idx_q   <= parent;
						state_q <= S_SU_A;
					end else begin
						state_q <= S_DONE;
					end
				end
				// Extract: capture root, then pop.
				S_EX_A: state_q <= S_EX_B;
				S_EX_B: begin
					res_q       <= rdata;
					res_valid_q <= 1'b1;
					ret_q       <= RET_DONE;
					state_q     <= S_POP;
				end
				S_POP: begin
					cur_q   <= rdata;
					count_q <= count_q - CW'(1);
					idx_q   <= '0;
					state_q <= S_SD_A;
				end
				// Build: sift down every inner node from the bottom up.
				S_BH_A: begin
					if (bi_q == '0) begin
						state_q <= S_ZR_A;
					end else begin
						bi_q    <= bi_q - AW'(1);
						state_q <= S_BH_B;
					end
				end
				S_BH_B: begin
					cur_q   <= rdata;
					idx_q   <= bi_q;
					ret_q   <= RET_BUILD;
					state_q <= S_SD_A;
				end
				// Remove zero-frequency roots.
				S_ZR_A: state_q <= (count_q == '0) ? S_DM_A : S_ZR_B;
				S_ZR_B: begin
					if (rdata.freq == '0) begin
						ret_q   <= RET_ZERO;
						state_q <= S_POP;
					end else begin
						state_q <= S_DM_A;
					end
				end
				// Pad a lone entry with a dummy.
				S_DM_A: state_q <= (count_q == CW'(1)) ? S_DM_B : S_DONE;
				S_DM_B: begin
					cur_q.freq <= '0;
					cur_q.sym  <= rdata.sym + 8'd1;
					cur_q.num  <= DUMMY_NUM;
					idx_q      <= AW'(count_q);
					count_q    <= count_q + CW'(1);
					state_q    <= S_SU_A;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign count_ext = {10'd0, count_q};

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
			out_valid_q  <= res_valid_q;
			out_entry_q  <= res_q;
			out_status_q <= status_q;
			out_count_q  <= count_ext[9:0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, out_count_q, out_entry_q.num, out_entry_q.sym, out_entry_q.freq};
	assign m_tuser  = {out_status_q, out_valid_q};

endmodule

// File: hw/rtl/mhpq_checker.sv
// Port-level checks for the min-heap priority queue.
// Depends on mhpq_pkg; bound to min_heap_priority_queue below.
module mhpq_checker import mhpq_pkg::*; #(
	parameter int CAPACITY = 512
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [55:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// A result with an entry always reports success.
	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[2:1] == ST_OK)
		else $error("extracted entry with error status");

	// The entry count never exceeds the capacity.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 32'(m_tdata[59:50]) <= 32'(CAPACITY) || CAPACITY > 1023)
		else $error("entry count above capacity");

	// Only one transaction is in work at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed under stall");

endmodule

bind min_heap_priority_queue mhpq_checker #(.CAPACITY(CAPACITY)) u_mhpq_checker (.*);

// File: dv/tb_top.sv
// Self-checking testbench for the min-heap priority queue: drives operations on the
// input stream, predicts every result with its own heap image and checks the output stream.
// Depends on mhpq_pkg and min_heap_priority_queue from the RTL.
`timescale 1ns / 1ps

module tb_top;
	import mhpq_pkg::*;

	localparam int DEPTH = 512;

	// Expected content of one output transaction.
	typedef struct {
		logic        got;
		logic [31:0] freq;
		logic [7:0]  sym;
		logic [9:0]  num;
		status_t     status;
		logic [9:0]  count;
	} heap_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic [2:0]  m_tuser;

	entry_t       heap_img [DEPTH];
	int           heap_cnt;
	heap_result_t pending_results [$];
	int           errors;
	int           sent_items;
	int           checked_results;
	int           extracted_entries;
	int           hold_off_cycles;
	bit           sender_idles;
	bit           receiver_stalls;

	min_heap_priority_queue #(.CAPACITY(DEPTH)) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// ---------------- heap image ----------------

	function automatic void img_swap(int a, int b);
		entry_t t;
		t = heap_img[a];
		heap_img[a] = heap_img[b];
		heap_img[b] = t;
	endfunction

	function automatic void img_sift_down(int idx);
		int best;
		int l;
		int r;
		forever begin
			best = idx;
			l = 2 * idx + 1;
			r = 2 * idx + 2;
			if (l < heap_cnt && heap_img[l].freq < heap_img[best].freq) best = l;
			if (r < heap_cnt && heap_img[r].freq < heap_img[best].freq) best = r;
			if (best == idx) return;
			img_swap(idx, best);
			idx = best;
		end
	endfunction

	function automatic void img_sift_up(int idx);
		int parent;
		while (idx != 0) begin
			parent = (idx - 1) / 2;
			if (!(heap_img[idx].freq < heap_img[parent].freq)) return;
			img_swap(idx, parent);
			idx = parent;
		end
	endfunction

	function automatic void img_pop_root();
		heap_img[0] = heap_img[heap_cnt - 1];
		heap_cnt--;
		img_sift_down(0);
	endfunction

	function automatic void img_build();
		int i;
		entry_t d;
		for (i = heap_cnt / 2 - 1; i >= 0; i--) img_sift_down(i);
		while (heap_cnt > 0 && heap_img[0].freq == 32'd0) img_pop_root();
		// A lone survivor gets a zero-frequency dummy partner.
		if (heap_cnt == 1 && heap_cnt < DEPTH) begin
			d.freq = 32'd0;
			d.sym  = heap_img[0].sym + 8'd1;
			d.num  = DUMMY_NUM;
			heap_img[heap_cnt] = d;
			img_sift_up(heap_cnt);
			heap_cnt++;
		end
	endfunction

	// Apply one accepted operation to the image and queue the result it must produce.
	function automatic void predict_heap_op(op_t op, entry_t e);
		heap_result_t r;
		r.got    = 1'b0;
		r.freq   = '0;
		r.sym    = '0;
		r.num    = '0;
		r.status = ST_OK;
		case (op)
			OP_LOAD, OP_INSERT: begin
				if (heap_cnt >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					heap_img[heap_cnt] = e;
					if (op == OP_INSERT) img_sift_up(heap_cnt);
					heap_cnt++;
				end
			end
			OP_BUILD: img_build();
			default: begin
				if (heap_cnt == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.got  = 1'b1;
					r.freq = heap_img[0].freq;
					r.sym  = heap_img[0].sym;
					r.num  = heap_img[0].num;
					img_pop_root();
				end
			end
		endcase
		r.count = heap_cnt[9:0];
		pending_results.push_back(r);
	endfunction

	// ---------------- checking ----------------

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
	endtask

	// Compare each output transaction with the oldest expectation.
	always @(posedge clk) begin
		heap_result_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected transaction", m_tdata[31:0], 32'd0);
			end else begin
				w = pending_results.pop_front();
				checked_results++;
				if (w.got) extracted_entries++;
				if (m_tuser[0] !== w.got)
					report_mismatch("out_valid", 32'(m_tuser[0]), 32'(w.got));
				if (m_tuser[2:1] !== w.status)
					report_mismatch("status", 32'(m_tuser[2:1]), 32'(w.status));
				if (m_tdata[31:0] !== w.freq) report_mismatch("frequency", m_tdata[31:0], w.freq);
				if (m_tdata[39:32] !== w.sym)
					report_mismatch("symbol", 32'(m_tdata[39:32]), 32'(w.sym));
				if (m_tdata[49:40] !== w.num)
					report_mismatch("node number", 32'(m_tdata[49:40]), 32'(w.num));
				if (m_tdata[59:50] !== w.count)
					report_mismatch("entry count", 32'(m_tdata[59:50]), 32'(w.count));
				if (m_tdata[63:60] !== 4'd0)
					report_mismatch("tdata padding", 32'(m_tdata[63:60]), 32'd0);
			end
		end
	end

	// Output ready: random stall bursts, plus a long hold-off on request.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// ---------------- stimulus ----------------

	// Offer one operation; it is predicted at the edge where it is accepted.
	task automatic send_op(op_t op, logic [31:0] f = 0, logic [7:0] s = 0,
			logic signed [9:0] n = 0);
		entry_t e;
		e.freq = f;
		e.sym  = s;
		e.num  = n;
		if (sender_idles && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {6'd0, e.num, e.sym, e.freq};
		do @(posedge clk); while (!s_tready);
		predict_heap_op(op, e);
		sent_items++;
	endtask

	// Stop offering and wait until every result has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_freq();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 3);
			1: return $urandom_range(0, 40);
			2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [9:0] rand_num();
		return $urandom_range(0, 7) == 0 ? DUMMY_NUM : 10'($urandom_range(0, 511));
	endfunction

	// Empty-heap corner cases straight after reset.
	task automatic test_empty_heap();
		send_op(OP_EXTRACT);
		send_op(OP_BUILD);
		send_op(OP_EXTRACT);
		wait_drained();
	endtask

	// Field extremes, zero removal in build, ties and the lone-entry dummy.
	task automatic test_directed();
		send_op(OP_LOAD, 32'hFFFF_FFFF, 8'hFF, 10'sd511);
		send_op(OP_LOAD, 32'd0, 8'h00, DUMMY_NUM);
		send_op(OP_LOAD, 32'd0, 8'h12, 10'sd0);
		send_op(OP_LOAD, 32'd7, 8'hFF, 10'sd3);
		send_op(OP_BUILD);
		// Only the 32'hFFFF_FFFF and 7 entries survive; no dummy is added.
		send_op(OP_EXTRACT);
		send_op(OP_BUILD);
		// A single entry left: build pairs it with a dummy whose symbol wraps.
		send_op(OP_EXTRACT);
		send_op(OP_EXTRACT);
		send_op(OP_EXTRACT);
		// Equal keys come out in the order that the heap's tie rule gives.
		send_op(OP_INSERT, 32'd5, 8'hA1, 10'sd1);
		send_op(OP_INSERT, 32'd5, 8'hA2, 10'sd2);
		send_op(OP_INSERT, 32'd5, 8'hA3, 10'sd3);
		send_op(OP_INSERT, 32'd1, 8'h55, 10'sd256);
		send_op(OP_INSERT, 32'd5, 8'hAA, 10'sd170);
		repeat (6) send_op(OP_EXTRACT);
		// All-zero heap: build removes everything.
		send_op(OP_LOAD, 32'd0, 8'h01, 10'sd9);
		send_op(OP_LOAD, 32'd0, 8'h02, 10'sd9);
		send_op(OP_BUILD);
		send_op(OP_EXTRACT);
		wait_drained();
	endtask

	// Fill the heap to capacity with mostly zero keys, hit the full flag,
	// then build (which strips the zeros) and drain what is left.
	task automatic test_full_heap();
		repeat (DEPTH)
			send_op(OP_LOAD, ($urandom_range(0, 15) == 0) ? rand_freq() : 32'd0,
				8'($urandom), rand_num());
		send_op(OP_LOAD, 32'd1, 8'h01, 10'sd1);
		send_op(OP_INSERT, 32'd1, 8'h01, 10'sd1);
		send_op(OP_BUILD);
		wait_drained();
		while (heap_cnt > 0) send_op(OP_EXTRACT);
		send_op(OP_EXTRACT);
		wait_drained();
	endtask

	// Hold the output off for a long stretch while inserts keep coming.
	task automatic test_back_pressure();
		hold_off_cycles = 300;
		repeat (20) send_op(OP_INSERT, rand_freq(), 8'($urandom), rand_num());
		repeat (21) send_op(OP_EXTRACT);
		wait_drained();
	endtask

	// Random runs: mostly load-build-use sequences, with loose operations mixed in.
	task automatic test_random(int n_items);
		int done;
		int k;
		int pick;
		done = 0;
		while (done < n_items) begin
			if ($urandom_range(0, 3) != 0) begin
				k = $urandom_range(0, 12);
				repeat (k) send_op(OP_LOAD, rand_freq(), 8'($urandom), rand_num());
				send_op(OP_BUILD);
				done += k + 1;
			end
			repeat ($urandom_range(4, 20)) begin
				pick = $urandom_range(0, 9);
				if (pick < 4 && heap_cnt < 40)
					send_op(OP_INSERT, rand_freq(), 8'($urandom), rand_num());
				else if (pick < 5)
					send_op(OP_LOAD, rand_freq(), 8'($urandom), rand_num());
				else if (pick < 6)
					send_op(OP_BUILD);
				else
					send_op(OP_EXTRACT);
				done++;
			end
			if ($urandom_range(0, 5) == 0) wait_drained();
		end
		wait_drained();
	endtask

	// ---------------- sequence ----------------

	initial begin
		errors = 0;
		sent_items = 0;
		checked_results = 0;
		extracted_entries = 0;
		hold_off_cycles = 0;
		heap_cnt = 0;
		sender_idles = 1'b1;
		receiver_stalls = 1'b1;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_LOAD;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_heap();
		test_directed();
		test_back_pressure();
		test_full_heap();
		test_random(180);
		sender_idles = 1'b0;
		receiver_stalls = 1'b0;
		test_random(80);
		while (heap_cnt > 0) send_op(OP_EXTRACT);
		wait_drained();
		repeat (50) @(posedge clk);

		$display("Covered %0d operations (load, build, insert, extract) with %0d results checked,",
			sent_items, checked_results);
		$display("%0d entries extracted, including empty and full heap flags and long back-pressure.",
			extracted_entries);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: min_heap_priority_queue.f
hw/rtl/mhpq_pkg.sv
hw/rtl/mhpq_store.sv
hw/rtl/min_heap_priority_queue.sv
hw/rtl/mhpq_checker.sv
dv/tb_top.sv
